// File: rtl/core/assert_macros.svh
// Assertion macros shared by the extractor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, masked while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds on a clock edge.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

// File: rtl/core/dfce_pkg.sv
// Types, constants and helper functions for the dollar format code extractor.
`timescale 1ns / 1ps

package dfce_pkg;

  localparam int ByteW = 8;
  localparam int LenW = 3;
  localparam int ClassW = 2;
  localparam int PosW = 16;
  localparam int MaxPos = 65535;
  localparam int DefCounterWidth = 16;
  localparam int NumSlots = 3;

  localparam logic [ByteW-1:0] Dollar = 8'h24;
  localparam logic [ByteW-1:0] CaseBit = 8'h20;

  localparam logic KindText = 1'b0;
  localparam logic KindCode = 1'b1;

  typedef enum logic [ClassW-1:0] {
    ClassColour      = 2'd0,
    ClassUnsupported = 2'd1,
    ClassStyle       = 2'd2
  } class_e;

  // One accepted input beat.
  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_text;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] out_byte;
    logic [ByteW-1:0] code_byte1;
    logic [ByteW-1:0] code_byte2;
    logic [ByteW-1:0] code_byte3;
    logic [LenW-1:0]  code_length;
    class_e           code_class;
    logic [PosW-1:0]  code_position;
    logic             last;
  } res_t;

  // All results caused by one input beat, packed from slot 0 upward.
  typedef struct packed {
    logic [1:0]               n;
    res_t [NumSlots-1:0]      slot;
  } batch_t;

  function automatic logic is_hex(logic [ByteW-1:0] c);
    return ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "f")) ||
           ((c >= "A") && (c <= "F"));
  endfunction

  // Class of a code from its first byte after the dollar sign.
  function automatic class_e classify(logic [ByteW-1:0] c);
    logic [ByteW-1:0] lc;
    class_e           cls;
    lc = ((c >= "A") && (c <= "Z")) ? (c | CaseBit) : c;
    if (is_hex(lc)) begin
      cls = ClassColour;
    end else begin
      case (lc)
        "i", "o", "w", "n", "m", "t", "s", "l", "g", "z", "p": cls = ClassStyle;
        default: cls = ClassUnsupported;
      endcase
    end
    return cls;
  endfunction

  function automatic res_t make_text(logic [ByteW-1:0] c);
    res_t r;
    r = '0;
    r.kind = KindText;
    r.out_byte = c;
    return r;
  endfunction

  function automatic res_t make_code(logic [2:0][ByteW-1:0] bytes, logic [LenW-1:0] len,
                                     logic [PosW-1:0] pos);
    res_t r;
    r = '0;
    r.kind = KindCode;
    r.code_byte1 = bytes[0];
    r.code_byte2 = bytes[1];
    r.code_byte3 = bytes[2];
    r.code_length = len;
    r.code_class = classify(bytes[0]);
    r.code_position = pos;
    return r;
  endfunction

endpackage

// File: rtl/core/dfce_if.sv
// Stream interfaces for the extractor input and result channels.
`timescale 1ns / 1ps

interface dfce_in_if;
  logic                        valid;
  logic                        ready;
  logic [dfce_pkg::ByteW-1:0]  in_byte;
  logic                        end_of_text;

  modport source (output valid, in_byte, end_of_text, input ready);
  modport sink (input valid, in_byte, end_of_text, output ready);
endinterface

interface dfce_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [dfce_pkg::ByteW-1:0]  out_byte;
  logic [dfce_pkg::ByteW-1:0]  code_byte1;
  logic [dfce_pkg::ByteW-1:0]  code_byte2;
  logic [dfce_pkg::ByteW-1:0]  code_byte3;
  logic [dfce_pkg::LenW-1:0]   code_length;
  logic [dfce_pkg::ClassW-1:0] code_class;
  logic [dfce_pkg::PosW-1:0]   code_position;
  logic                        last;

  modport source (output valid, kind, out_byte, code_byte1, code_byte2, code_byte3,
                  code_length, code_class, code_position, last, input ready);
  modport sink (input valid, kind, out_byte, code_byte1, code_byte2, code_byte3,
                code_length, code_class, code_position, last, output ready);
endinterface

// File: rtl/core/dfce_in_stage.sv
// Input register: holds one accepted beat until the step logic takes it.
`timescale 1ns / 1ps

module dfce_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  dfce_in_if.sink             in_i,
  input  logic                take_i,
  output logic                vld_o,
  output dfce_pkg::item_t     item_o
);

  logic            vld_q, vld_d;
  dfce_pkg::item_t item_q, item_d;
  logic            acc;

  // Take a new beat when empty or when the held beat leaves this cycle
  assign in_i.ready = !vld_q || take_i;
  assign acc = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    item_d = item_q;
    if (acc) begin
      vld_d = 1'b1;
      item_d.in_byte = in_i.in_byte;
      item_d.end_of_text = in_i.end_of_text;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign vld_o = vld_q;
  assign item_o = item_q;

endmodule

// File: rtl/core/dfce_core.sv
// Per-byte step logic and extractor state: pending code, countdown and counters.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dfce_core #(
  parameter int CounterWidth = dfce_pkg::DefCounterWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  dfce_pkg::item_t    item_i,
  output dfce_pkg::batch_t   batch_o
);

  localparam int WideW = (CounterWidth + 3 > 18) ? CounterWidth + 3 : 18;
  localparam int BW = dfce_pkg::ByteW;
  localparam int LW = dfce_pkg::LenW;

  logic [2:0][BW-1:0]      pend_q, pend_d;
  logic [LW-1:0]           plen_q, plen_d;
  logic [1:0]              cd_q, cd_d;
  logic [CounterWidth-1:0] seen_q, seen_d;
  logic [CounterWidth-1:0] esc_q, esc_d;
  logic [CounterWidth-1:0] emt_q, emt_d;

  logic [2:0][BW-1:0]      pend1, pend2;
  logic [LW-1:0]           plen1, plen2;
  logic [1:0]              cd1, cd2, cd3;
  logic                    emit_a, emit_c, used, esc_inc, do_push, is_dollar;
  logic [CounterWidth-1:0] seen_n, esc_n, emt_n;
  logic [CounterWidth:0]   emt_sum;
  logic [BW-1:0]           c;

  dfce_pkg::res_t          cand [dfce_pkg::NumSlots];
  logic                    cand_v [dfce_pkg::NumSlots];
  dfce_pkg::batch_t        batch;
  logic [1:0]              idx;

  // Position within stripped text, clamped to the result field range
  function automatic logic [dfce_pkg::PosW-1:0] code_pos(logic [CounterWidth-1:0] seen,
                                                          logic [LW-1:0] len,
                                                          logic [CounterWidth-1:0] esc,
                                                          logic [CounterWidth-1:0] emt);
    logic signed [WideW-1:0] diff;
    logic [dfce_pkg::PosW-1:0] pos;
    diff = $signed(WideW'(seen)) - $signed(WideW'(len)) - $signed(WideW'(esc))
         - $signed(WideW'(emt));
    if (diff < 0) begin
      pos = '0;
    end else if (diff > $signed(WideW'(dfce_pkg::MaxPos))) begin
      pos = '1;
    end else begin
      pos = diff[dfce_pkg::PosW-1:0];
    end
    return pos;
  endfunction

  assign c = item_i.in_byte;
  assign is_dollar = (c == dfce_pkg::Dollar);

  // Work out one step: expired code, byte handling, countdown, flush
  always_comb begin
    emit_a = (cd_q == 2'd0) && (plen_q != '0);
    pend1 = emit_a ? '0 : pend_q;
    plen1 = emit_a ? '0 : plen_q;
    cd1 = (cd_q == 2'd0) ? 2'd1 : cd_q;

    pend2 = pend1;
    plen2 = plen1;
    cd2 = cd1;
    esc_inc = 1'b0;
    used = 1'b0;
    do_push = 1'b0;

    if (is_dollar) begin
      pend2 = '0;
      if (plen1 != '0) begin
        // cancel the pending code, pass one dollar through
        cd2 = 2'd1;
        plen2 = '0;
        esc_inc = 1'b1;
      end else begin
        cd2 = 2'd2;
        plen2 = LW'(1);
        used = 1'b1;
      end
    end else if (dfce_pkg::is_hex(c) && (plen1 != '0)) begin
      if (plen1 == LW'(1)) begin
        cd2 = 2'd3;
      end
      do_push = 1'b1;
      used = 1'b1;
    end else if (plen1 == LW'(1)) begin
      do_push = 1'b1;
      used = 1'b1;
    end

    if (do_push && (plen1 >= LW'(1)) && (plen1 <= LW'(3))) begin
      pend2[2'(plen1 - LW'(1))] = c;
      plen2 = plen1 + LW'(1);
    end

    cd3 = (cd2 != 2'd0) ? cd2 - 2'd1 : 2'd0;

    // saturating counters
    seen_n = (&seen_q) ? seen_q : seen_q + CounterWidth'(1);
    esc_n = (esc_inc && !(&esc_q)) ? esc_q + CounterWidth'(1) : esc_q;
    emt_sum = {1'b0, emt_q} + (CounterWidth + 1)'(plen_q);
    if (!emit_a) begin
      emt_n = emt_q;
    end else if (emt_sum[CounterWidth]) begin
      emt_n = '1;
    end else begin
      emt_n = emt_sum[CounterWidth-1:0];
    end

    emit_c = item_i.end_of_text && (plen2 > LW'(1));
  end

  // Gather results in order: expired code, text byte, flushed code
  always_comb begin
    cand[0] = dfce_pkg::make_code(pend_q, plen_q, code_pos(seen_q, plen_q, esc_q, emt_q));
    cand_v[0] = emit_a;
    cand[1] = dfce_pkg::make_text(c);
    cand_v[1] = !used;
    cand[2] = dfce_pkg::make_code(pend2, plen2, code_pos(seen_n, plen2, esc_n, emt_n));
    cand_v[2] = emit_c;

    batch = '0;
    idx = 2'd0;
    for (int i = 0; i < dfce_pkg::NumSlots; i++) begin
      if (cand_v[i]) begin
        batch.slot[idx] = cand[i];
        idx = idx + 2'd1;
      end
    end
    if (idx != 2'd0) begin
      batch.slot[idx - 2'd1].last = 1'b1;
    end
    batch.n = idx;
  end

  assign batch_o = batch;

  // Advance state; the end of text returns everything to reset values
  always_comb begin
    pend_d = pend_q;
    plen_d = plen_q;
    cd_d = cd_q;
    seen_d = seen_q;
    esc_d = esc_q;
    emt_d = emt_q;
    if (step_i) begin
      if (item_i.end_of_text) begin
        pend_d = '0;
        plen_d = '0;
        cd_d = 2'd0;
        seen_d = '0;
        esc_d = '0;
        emt_d = '0;
      end else begin
        pend_d = pend2;
        plen_d = plen2;
        cd_d = cd3;
        seen_d = seen_n;
        esc_d = esc_n;
        emt_d = emt_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      plen_q <= '0;
      cd_q <= 2'd0;
      seen_q <= '0;
      esc_q <= '0;
      emt_q <= '0;
    end else begin
      pend_q <= pend_d;
      plen_q <= plen_d;
      cd_q <= cd_d;
      seen_q <= seen_d;
      esc_q <= esc_d;
      emt_q <= emt_d;
    end
  end

  // An expired code clears the pending code, so no flush can follow it
  `ASSERT_NEVER(a_two_codes, step_i && emit_a && emit_c, "expired and flushed code in one step")
  // The pending length never passes the longest code
  `ASSERT_CLK(a_plen_range, plen_q <= LW'(4), "pending code length out of range")

endmodule

// File: rtl/core/dfce_res_q.sv
// Result register bank: takes a step's results and drains them one beat at a time.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dfce_res_q (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ld_i,
  input  dfce_pkg::batch_t   batch_i,
  output logic               can_load_o,
  dfce_out_if.source         out_o
);

  dfce_pkg::res_t [dfce_pkg::NumSlots-1:0] slot_q, slot_d;
  logic [1:0]                              cnt_q, cnt_d;
  logic                                    pop;

  assign pop = (cnt_q != 2'd0) && out_o.ready;
  // Room for a new batch once the last held beat goes out
  assign can_load_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_comb begin
    slot_d = slot_q;
    cnt_d = cnt_q;
    if (ld_i) begin
      slot_d = batch_i.slot;
      cnt_d = batch_i.n;
    end else if (pop) begin
      slot_d = {dfce_pkg::res_t'('0), slot_q[dfce_pkg::NumSlots-1:1]};
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  // Drive the head beat
  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.kind = slot_q[0].kind;
  assign out_o.out_byte = slot_q[0].out_byte;
  assign out_o.code_byte1 = slot_q[0].code_byte1;
  assign out_o.code_byte2 = slot_q[0].code_byte2;
  assign out_o.code_byte3 = slot_q[0].code_byte3;
  assign out_o.code_length = slot_q[0].code_length;
  assign out_o.code_class = slot_q[0].code_class;
  assign out_o.code_position = slot_q[0].code_position;
  assign out_o.last = slot_q[0].last;

  `ASSERT_CLK(a_load_room, ld_i |-> ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop)),
              "batch loaded over undrained results")
  `ASSERT_CLK(a_last_tail, ((cnt_q != 2'd0) && slot_q[0].last) |-> (cnt_q == 2'd1),
              "last flag on a beat that is not the final one held")

endmodule

// File: rtl/core/dollar_format_code_extractor.sv
// Top level of the dollar format code extractor.
//
//   channel | dir | payload                                              | handshake
//   in_i    | in  | in_byte, end_of_text                                 | valid/ready
//   out_o   | out | kind, out_byte, code bytes, length, class, pos, last | valid/ready
//
// One byte per cycle while out_o takes every result and no byte yields two: a beat
// sits in the input register, then the step logic writes its zero to two results
// into the result register bank, which drives the first result of the beat on out_o.
// Results drain at one per cycle while out_o is ready, so a byte that yields two
// results holds the next byte in the input register until the first one drains.
// Reset clears the control and extractor state at once; there is no clearing pass.
// A stalled output keeps the input register full and back-pressures in_i.
`timescale 1ns / 1ps

module dollar_format_code_extractor #(
  parameter int CounterWidth = dfce_pkg::DefCounterWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dfce_in_if.sink      in_i,
  dfce_out_if.source   out_o
);

  logic             in_vld;
  logic             can_load;
  logic             step;
  dfce_pkg::item_t  item;
  dfce_pkg::batch_t batch;

  // Step when a byte is held and the result bank has room
  assign step = in_vld && can_load;

  dfce_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .take_i (step),
    .vld_o  (in_vld),
    .item_o (item)
  );

  dfce_core #(
    .CounterWidth (CounterWidth)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item),
    .batch_o (batch)
  );

  dfce_res_q u_res_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_i       (step),
    .batch_i    (batch),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule
